// ----- rtl/core/ttasm_pkg.sv -----
package ttasm_pkg;

  // Default width of the line counter
  localparam int LINE_WIDTH_DEF = 16;

  // Number of tokens in one statement "ss,tt->nn,cc,D;"
  localparam logic [3:0] STMT_TOKENS = 4'd10;

  typedef enum logic [2:0] {
    TK_HEX,
    TK_COMMA,
    TK_SEMI,
    TK_ARROW,
    TK_DIR
  } tok_kind_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_SYNTAX,
    ST_UNTERM,
    ST_MALFORMED,
    ST_INCOMPLETE
  } status_t;

  // One classified byte, handed from the lexer to the parser
  typedef struct packed {
    logic      tok;     // a complete token was formed
    tok_kind_t kind;
    logic [7:0] data;   // hex value or direction bit
    logic      syntax;  // bad byte: lexer stops
    logic      fin;     // input ends with this byte
    logic      unterm;  // input ended inside a number or an arrow
  } ttasm_evt_t;

  localparam int EVT_W = $bits(ttasm_evt_t);

  // Token kind expected at each place of a statement
  function automatic tok_kind_t expected_kind(input logic [3:0] pos);
    tok_kind_t k;
    case (pos)
      4'd0: k = TK_HEX;
      4'd1: k = TK_COMMA;
      4'd2: k = TK_HEX;
      4'd3: k = TK_ARROW;
      4'd4: k = TK_HEX;
      4'd5: k = TK_COMMA;
      4'd6: k = TK_HEX;
      4'd7: k = TK_COMMA;
      4'd8: k = TK_DIR;
      4'd9: k = TK_SEMI;
      default: k = TK_HEX;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/core/ttasm_front.sv -----
module ttasm_front
  import ttasm_pkg::*;
#(
  parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,       // byte accepted this cycle
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  output ttasm_evt_t            evt,
  output logic [LINE_WIDTH-1:0] evt_line
);

  localparam logic [LINE_WIDTH-1:0] LINE_TOP = {LINE_WIDTH{1'b1}};
  localparam logic [7:0] CH_EOF   = 8'hFF;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] UP_MASK  = 8'hDF;
  localparam logic [7:0] DIG_OFS  = 8'd48;
  localparam logic [7:0] LET_OFS  = 8'd55;

  typedef enum logic [1:0] {
    LX_READY,
    LX_NUMBER,
    LX_ARROW,
    LX_COMMENT
  } lex_mode_t;

  lex_mode_t             mode_r, mode_nxt;
  logic [3:0]            hi_r, hi_nxt;
  logic [LINE_WIDTH-1:0] line_r, line_nxt;
  logic                  stop_r, stop_nxt;

  function automatic logic is_hex(input logic [7:0] ch);
    return (ch >= 8'd48 && ch <= 8'd57) || (ch >= 8'd65 && ch <= 8'd70) ||
           (ch >= 8'd97 && ch <= 8'd102);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] ch);
    logic [7:0] v;
    if (ch <= 8'd57) v = ch - DIG_OFS;
    else             v = (ch & UP_MASK) - LET_OFS;
    return v[3:0];
  endfunction

  function automatic logic is_blank(input logic [7:0] ch);
    return ch == 8'd32 || (ch >= 8'd9 && ch <= 8'd13);
  endfunction

  function automatic logic is_dir(input logic [7:0] ch);
    return ch == 8'h52 || ch == 8'h72 || ch == 8'h4C || ch == 8'h6C;
  endfunction

  // Classify the byte and work out the next lexer state
  always_comb begin
    logic handled;
    handled  = 1'b0;
    evt      = '0;
    mode_nxt = mode_r;
    hi_nxt   = hi_r;
    line_nxt = line_r;
    stop_nxt = stop_r;
    if (!stop_r) begin
      if (in_byte == CH_EOF) begin
        evt.fin    = 1'b1;
        evt.unterm = (mode_r == LX_NUMBER) || (mode_r == LX_ARROW);
        stop_nxt   = 1'b1;
      end else begin
        if (mode_r == LX_COMMENT) begin
          if (in_byte != CH_LF) handled = 1'b1;
          else                  mode_nxt = LX_READY;
        end else if (in_byte == CH_HASH) begin
          mode_nxt = LX_COMMENT;
          handled  = 1'b1;
        end
        if (!handled) begin
          if (in_byte == CH_LF && line_r != LINE_TOP) line_nxt = line_r + LINE_WIDTH'(1);
          if (is_blank(in_byte)) begin
            // skip
          end else if (mode_nxt == LX_READY && is_hex(in_byte)) begin
            hi_nxt   = hex_val(in_byte);
            mode_nxt = LX_NUMBER;
          end else if (mode_nxt == LX_NUMBER && is_hex(in_byte)) begin
            mode_nxt = LX_READY;
            evt.tok  = 1'b1;
            evt.kind = TK_HEX;
            evt.data = {hi_r, hex_val(in_byte)};
          end else if (mode_nxt == LX_READY &&
                       (in_byte == CH_SEMI || in_byte == CH_COMMA)) begin
            evt.tok  = 1'b1;
            evt.kind = (in_byte == CH_SEMI) ? TK_SEMI : TK_COMMA;
          end else if (mode_nxt == LX_READY && in_byte == CH_DASH) begin
            mode_nxt = LX_ARROW;
          end else if (mode_nxt == LX_ARROW && in_byte == CH_GT) begin
            mode_nxt = LX_READY;
            evt.tok  = 1'b1;
            evt.kind = TK_ARROW;
          end else if (mode_nxt == LX_READY && is_dir(in_byte)) begin
            evt.tok  = 1'b1;
            evt.kind = TK_DIR;
            evt.data = {7'd0, (in_byte == 8'h52 || in_byte == 8'h72)};
          end else begin
            evt.syntax = 1'b1;
            stop_nxt   = 1'b1;
          end
        end
        if (!stop_nxt && in_last) begin
          evt.fin    = 1'b1;
          evt.unterm = (mode_nxt == LX_NUMBER) || (mode_nxt == LX_ARROW);
          stop_nxt   = 1'b1;
        end
      end
    end
    evt_line = line_nxt;
  end

  // Hold lexer state; advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= LX_READY;
      hi_r   <= '0;
      line_r <= LINE_WIDTH'(1);
      stop_r <= 1'b0;
    end else if (take) begin
      mode_r <= mode_nxt;
      hi_r   <= hi_nxt;
      line_r <= line_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

// ----- rtl/core/ttasm_queue.sv -----
module ttasm_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wptr_r, rptr_r;
  logic [1:0]       count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_data  = slot_r[rptr_r];

  // Store pushed beats
  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= push_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- rtl/core/ttasm_back.sv -----
module ttasm_back
  import ttasm_pkg::*;
#(
  parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  ttasm_evt_t            evt,
  input  logic [LINE_WIDTH-1:0] evt_line,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [55:0]           out_tdata
);

  logic [3:0]            tp_r, tp_nxt;
  logic [7:0]            from_r, from_nxt;
  logic [7:0]            tape_r, tape_nxt;
  logic [7:0]            to_r, to_nxt;
  logic [7:0]            new_r, new_nxt;
  logic                  dir_r, dir_nxt;
  logic [LINE_WIDTH-1:0] ltl_r, ltl_nxt;
  status_t               err_r, err_nxt;
  logic [LINE_WIDTH-1:0] errl_r, errl_nxt;
  logic                  stop_r, stop_nxt;
  logic                  emit;

  logic                  ovalid_r;
  logic [55:0]           odata_r, odata_nxt;

  assign pop = head_valid && (!ovalid_r || out_tready);

  // Parse one event: token first, then lexer error or end of input
  always_comb begin
    logic [3:0] pos;
    pos      = '0;
    tp_nxt   = tp_r;
    from_nxt = from_r;
    tape_nxt = tape_r;
    to_nxt   = to_r;
    new_nxt  = new_r;
    dir_nxt  = dir_r;
    ltl_nxt  = ltl_r;
    err_nxt  = err_r;
    errl_nxt = errl_r;
    stop_nxt = stop_r;
    emit     = 1'b0;
    if (!stop_r) begin
      if (evt.tok) begin
        ltl_nxt = evt_line;
        if (err_r == ST_OK) begin
          pos = (tp_r >= STMT_TOKENS) ? 4'd0 : tp_r;
          if (evt.kind != expected_kind(pos)) begin
            err_nxt  = ST_MALFORMED;
            errl_nxt = evt_line;
          end else begin
            tp_nxt = pos + 4'd1;
            case (pos)
              4'd0: from_nxt = evt.data;
              4'd2: tape_nxt = evt.data;
              4'd4: to_nxt   = evt.data;
              4'd6: new_nxt  = evt.data;
              4'd8: dir_nxt  = evt.data[0];
              4'd9: begin
                tp_nxt = 4'd0;
                emit   = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end
      if (evt.syntax) begin
        err_nxt  = ST_SYNTAX;
        errl_nxt = evt_line;
        stop_nxt = 1'b1;
      end
      if (evt.fin) begin
        if (evt.unterm) begin
          err_nxt  = ST_UNTERM;
          errl_nxt = evt_line;
        end else if (err_nxt == ST_OK && tp_nxt != 4'd0) begin
          err_nxt  = ST_INCOMPLETE;
          errl_nxt = ltl_nxt;
        end
        stop_nxt = 1'b1;
      end
    end
  end

  // Build the result beat
  always_comb begin
    logic [15:0] addr;
    logic [7:0]  flags;
    logic [15:0] eline;
    addr  = {from_nxt, 8'h00} + {7'd0, tape_nxt, 1'b0};
    flags = {dir_nxt, new_nxt[6:0]};
    eline = (errl_nxt > LINE_WIDTH'(16'hFFFF)) ? 16'hFFFF : 16'(errl_nxt);
    odata_nxt = {3'd0, eline, 3'(err_nxt), stop_nxt,
                 emit ? to_nxt : 8'h00, emit ? flags : 8'h00,
                 emit ? addr : 16'h0000, emit};
  end

  // Hold parser state; advance on each event taken from the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_r   <= '0;
      from_r <= '0;
      tape_r <= '0;
      to_r   <= '0;
      new_r  <= '0;
      dir_r  <= 1'b0;
      ltl_r  <= '0;
      err_r  <= ST_OK;
      errl_r <= '0;
      stop_r <= 1'b0;
    end else if (pop) begin
      tp_r   <= tp_nxt;
      from_r <= from_nxt;
      tape_r <= tape_nxt;
      to_r   <= to_nxt;
      new_r  <= new_nxt;
      dir_r  <= dir_nxt;
      ltl_r  <= ltl_nxt;
      err_r  <= err_nxt;
      errl_r <= errl_nxt;
      stop_r <= stop_nxt;
    end
  end

  // Output register: load on pop, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (pop) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) odata_r <= odata_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

`ifndef SYNTHESIS
  a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |=> stop_r)
    else $error("parser stop flag cleared");

  a_err_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ST_OK) |=> (err_r != ST_OK))
    else $error("error status cleared");

  a_ok_no_line: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r == ST_OK) |-> (errl_r == '0))
    else $error("error line set without error");

  a_no_emit_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && err_r != ST_OK) |=> !out_tdata[0])
    else $error("entry emitted after error");
`endif

endmodule

// ----- rtl/core/transition_table_assembler_unit.sv -----
// Transition table assembler.
// Input channel in_*: one source text byte per beat in in_tdata[7:0];
// in_tlast marks end of input after that byte, and a 0xFF byte ends it too.
// Output channel out_*: exactly one result beat for every input beat, in
// order. A result carries entry_valid, the table entry of a statement that
// completed with that byte (address, flags, next state), the done flag,
// the status code and the error line.
// A byte's event is written into the queue when the byte is accepted;
// the parser takes it from the queue head and loads the output register.
// Throughput: one byte per cycle while the receiver keeps up; the lexer
// classifies a byte combinationally and the parser consumes one queued
// event per cycle. A two-entry queue sits between lexer and parser, and
// an output register follows the parser; when the receiver stalls, the
// queue fills and in_tready drops once both entries are taken.
// Reset (rst_n low, synchronous) clears the lexer, the parser, the queue
// and the output valid flag; the line counter restarts at 1.
// After end of input or a syntax error, bytes are still accepted and
// answered with the held status and done set.
module transition_table_assembler_unit
  import ttasm_pkg::*;
#(
  parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // in_last
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] entry_valid, [16:1] entry_addr, [24:17] entry_flags,
  // [32:25] entry_next, [33] done_res, [36:34] status, [52:37] error_line
  output logic [55:0] out_tdata
);

  localparam int QW = LINE_WIDTH + EVT_W;

  ttasm_evt_t            f_evt, b_evt;
  logic [LINE_WIDTH-1:0] f_line, b_line;
  logic                  take, q_full, q_valid, q_pop;
  logic [QW-1:0]         q_head;

  assign in_tready = !q_full;
  assign take      = in_tvalid && in_tready;

  ttasm_front #(.LINE_WIDTH(LINE_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .evt      (f_evt),
    .evt_line (f_line)
  );

  ttasm_queue #(.WIDTH(QW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (take),
    .push_data  ({f_line, f_evt}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  assign b_evt  = q_head[EVT_W-1:0];
  assign b_line = q_head[QW-1:EVT_W];

  ttasm_back #(.LINE_WIDTH(LINE_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .evt        (b_evt),
    .evt_line   (b_line),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
